@@ hdl/sm_block_dispatcher_defines.svh @@
// Assertion macros used by the block dispatcher top level.
`ifndef SM_BLOCK_DISPATCHER_DEFINES_SVH
`define SM_BLOCK_DISPATCHER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SBD_ASSERT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SBD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

@@ hdl/sbd_pkg.sv @@
// Shared types, widths and codes of the block dispatcher.
`default_nettype none
package sbd_pkg;
	localparam int NUM_SMS_DEF      = 8;
	localparam int SLOTS_PER_SM_DEF = 8;
	localparam int WARP_SIZE_DEF    = 32;

	localparam int KID_W    = 8;
	localparam int CNT_W    = 7;
	localparam int TPB_W    = 11;
	localparam int SHM_W    = 21;
	localparam int RPT_W    = 8;
	localparam int REC_W    = KID_W + TPB_W + SHM_W + RPT_W;
	localparam int WARPS_W  = 7;
	localparam int REGS_W   = 21;
	localparam int BLK_W    = 4;
	localparam int SMS_W    = 4;
	localparam int SMIDX_W  = 3;
	localparam int STAT_W   = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 21;

	// record layout: kernel id, threads, shared bytes, regs per thread
	localparam int REC_T_LO = KID_W;
	localparam int REC_S_LO = KID_W + TPB_W;
	localparam int REC_R_LO = KID_W + TPB_W + SHM_W;

	localparam logic [CNT_W-1:0] MAX_LAUNCH = 7'd64;

	localparam logic [CFG_IDX_W-1:0] CFG_WARPS_LIMIT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SHARED_LIMIT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REGS_LIMIT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_LIMIT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SMS_IN_USE   = 3'd4;

	localparam logic [WARPS_W-1:0] WARPS_LIMIT_RST  = 7'd64;
	localparam logic [SHM_W-1:0]   SHARED_LIMIT_RST = 21'd49152;
	localparam logic [REGS_W-1:0]  REGS_LIMIT_RST   = 21'd65536;
	localparam logic [BLK_W-1:0]   BLOCKS_LIMIT_RST = 4'd8;
	localparam logic [SMS_W-1:0]   SMS_IN_USE_RST   = 4'd8;

	localparam logic [STAT_W-1:0] STAT_PLACING    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_ALL_PLACED = 2'd1;
	localparam logic [STAT_W-1:0] STAT_NO_FIT     = 2'd2;
	localparam logic [STAT_W-1:0] STAT_RELEASED   = 2'd3;

	localparam logic OP_LAUNCH  = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_SCAN,
		S_DRAIN
	} sbd_state_t;

	typedef struct packed {
		logic load;
		logic emit_empty;
		logic walk;
		logic scan;
		logic drain;
	} sbd_cmd_t;

	typedef struct packed {
		logic launch_empty;
		logic no_sms;
		logic walk_end;
		logic scan_end;
	} sbd_stat_t;
endpackage
`default_nettype wire

@@ hdl/sm_block_dispatcher.sv @@
// Top level of the thread-block dispatcher: sequencer plus datapath.
//
//  channel   | handshake                        | payload
//  ----------+----------------------------------+------------------------------------
//  command   | start / busy, taken when !busy   | op, kernel_id, block_count, thread_count,
//            |                                  | shared_per_block, regs_per_thread
//  result    | result_valid, one-cycle strobe   | sm_index, placed, status, unplaced, last
//  config    | cfg_valid / cfg_ready (always 1) | cfg_index, cfg_data
//
// A launch visits SMs along the parity walk (gaps of the odd/even
// passes included) and gives one result per placed block; the fit test
// reads the per-SM usage registers and decides in that same cycle.
// A release visits each resident block and each empty SM in use, then
// drains: the slot RAM's registered read puts the compaction one slot
// behind the scan. An empty launch answers in the cycle after acceptance.
// Reset clears the usage counters at once; the slot RAM needs no clearing
// pass as only slots below an SM's block count are read. Results cannot be
// stalled; busy drops with the final result of an item.
`default_nettype none
`include "sm_block_dispatcher_defines.svh"
module sm_block_dispatcher #(
	parameter int NUM_SMS      = sbd_pkg::NUM_SMS_DEF,
	parameter int SLOTS_PER_SM = sbd_pkg::SLOTS_PER_SM_DEF,
	parameter int WARP_SIZE    = sbd_pkg::WARP_SIZE_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic                           op,
	input  logic [sbd_pkg::KID_W-1:0]      kernel_id,
	input  logic [sbd_pkg::CNT_W-1:0]      block_count,
	input  logic [sbd_pkg::TPB_W-1:0]      thread_count,
	input  logic [sbd_pkg::SHM_W-1:0]      shared_per_block,
	input  logic [sbd_pkg::RPT_W-1:0]      regs_per_thread,
	output logic                           result_valid,
	output logic [sbd_pkg::SMIDX_W-1:0]    sm_index,
	output logic                           placed,
	output logic [sbd_pkg::STAT_W-1:0]     status,
	output logic [sbd_pkg::CNT_W-1:0]      unplaced,
	output logic                           last,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [sbd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sbd_pkg::CFG_DATA_W-1:0] cfg_data
);
	import sbd_pkg::*;

	sbd_cmd_t  cmd;
	sbd_stat_t stat;

	// sequencer: IDLE, launch WALK, release SCAN, DRAIN of the last slot
	sbd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	sbd_datapath #(
		.NUM_SMS      (NUM_SMS),
		.SLOTS_PER_SM (SLOTS_PER_SM),
		.WARP_SIZE    (WARP_SIZE)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.stat              (stat),
		.kernel_id         (kernel_id),
		.block_count       (block_count),
		.thread_count      (thread_count),
		.shared_per_block  (shared_per_block),
		.regs_per_thread   (regs_per_thread),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.result_valid      (result_valid),
		.sm_index          (sm_index),
		.placed            (placed),
		.status            (status),
		.unplaced          (unplaced),
		.last              (last)
	);

	// an item always closes with its final result as busy drops
	`SBD_ASSERT(a_end_has_last, clk, arst_n, $fell(busy), result_valid && last, "busy fell without final result")
	// a release result is always final, with nothing else set
	`SBD_ASSERT(a_release_result, clk, arst_n, result_valid && status == STAT_RELEASED, last && !placed && unplaced == '0, "bad release result")
	// a placement never carries a failure or release code
	`SBD_ASSERT(a_place_status, clk, arst_n, result_valid && placed, unplaced == '0 && (status == STAT_PLACING || status == STAT_ALL_PLACED), "bad placement result")
	// a release never answers at once; the block stays busy first
	`SBD_ASSERT_NEXT(a_release_busy, clk, arst_n, start && !busy && op == OP_RELEASE, busy && !result_valid, "release answered too early")
endmodule
`default_nettype wire

@@ hdl/sbd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sbd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

@@ hdl/sbd_ctrl.sv @@
// Sequencer of the block dispatcher: launch walk and release scan.
`default_nettype none
module sbd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              op,
	input  sbd_pkg::sbd_stat_t stat,
	output sbd_pkg::sbd_cmd_t  cmd,
	output logic              busy
);
	import sbd_pkg::*;

	sbd_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		case (state_q)
			S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					if (op == OP_RELEASE) begin
						state_d = stat.no_sms ? S_DRAIN : S_SCAN;
					end else if (stat.launch_empty) begin
						cmd.emit_empty = 1'b1;
					end else begin
						state_d = S_WALK;
					end
				end
			end
			S_WALK: begin
				cmd.walk = 1'b1;
				if (stat.walk_end) begin
					state_d = S_IDLE;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_end) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				// last record of the scan retires this cycle
				cmd.drain = 1'b1;
				state_d   = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end
endmodule
`default_nettype wire

@@ hdl/sbd_datapath.sv @@
// Datapath: limits, per-SM usage, slot records, fit test and results.
`default_nettype none
module sbd_datapath #(
	parameter int NUM_SMS      = sbd_pkg::NUM_SMS_DEF,
	parameter int SLOTS_PER_SM = sbd_pkg::SLOTS_PER_SM_DEF,
	parameter int WARP_SIZE    = sbd_pkg::WARP_SIZE_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  sbd_pkg::sbd_cmd_t                 cmd,
	output sbd_pkg::sbd_stat_t                stat,
	input  logic [sbd_pkg::KID_W-1:0]         kernel_id,
	input  logic [sbd_pkg::CNT_W-1:0]         block_count,
	input  logic [sbd_pkg::TPB_W-1:0]         thread_count,
	input  logic [sbd_pkg::SHM_W-1:0]         shared_per_block,
	input  logic [sbd_pkg::RPT_W-1:0]         regs_per_thread,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [sbd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sbd_pkg::CFG_DATA_W-1:0]    cfg_data,
	output logic                              result_valid,
	output logic [sbd_pkg::SMIDX_W-1:0]       sm_index,
	output logic                              placed,
	output logic [sbd_pkg::STAT_W-1:0]        status,
	output logic [sbd_pkg::CNT_W-1:0]         unplaced,
	output logic                              last
);
	import sbd_pkg::*;

	localparam int SW    = (NUM_SMS > 1) ? $clog2(NUM_SMS) : 1;
	localparam int JW    = (SLOTS_PER_SM > 1) ? $clog2(SLOTS_PER_SM) : 1;
	localparam int BW    = $clog2(SLOTS_PER_SM + 1);
	localparam int IW    = $clog2(NUM_SMS + 4);
	localparam int DEPTH = NUM_SMS * SLOTS_PER_SM;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int RW    = TPB_W + RPT_W;
	// warp rounding: multiply by a scaled reciprocal of the warp size,
	// exact for every rounded thread count below 2^(TPB_W+1)
	localparam int WK    = TPB_W + 8;
	localparam int PW    = TPB_W + WK + 2;
	localparam longint unsigned WM = ((64'd1 << WK) + WARP_SIZE - 1) / WARP_SIZE;

	// configuration
	logic [WARPS_W-1:0] warps_lim_q;
	logic [SHM_W-1:0]   shared_lim_q;
	logic [REGS_W-1:0]  regs_lim_q;
	logic [BLK_W-1:0]   blocks_lim_q;
	logic [SMS_W-1:0]   sms_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warps_lim_q  <= WARPS_LIMIT_RST;
			shared_lim_q <= SHARED_LIMIT_RST;
			regs_lim_q   <= REGS_LIMIT_RST;
			blocks_lim_q <= BLOCKS_LIMIT_RST;
			sms_q        <= SMS_IN_USE_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_WARPS_LIMIT:  warps_lim_q  <= cfg_data[WARPS_W-1:0];
				CFG_SHARED_LIMIT: shared_lim_q <= cfg_data[SHM_W-1:0];
				CFG_REGS_LIMIT:   regs_lim_q   <= cfg_data[REGS_W-1:0];
				CFG_BLOCKS_LIMIT: blocks_lim_q <= cfg_data[BLK_W-1:0];
				CFG_SMS_IN_USE:   sms_q        <= cfg_data[SMS_W-1:0];
				default: ;
			endcase
		end
	end

	logic [IW-1:0] eff_sms;
	logic [BW-1:0] eff_blk;

	assign eff_sms = (7'(sms_q) > 7'(NUM_SMS)) ? IW'(NUM_SMS) : IW'(sms_q);
	assign eff_blk = (6'(blocks_lim_q) > 6'(SLOTS_PER_SM)) ? BW'(SLOTS_PER_SM)
		: BW'(blocks_lim_q);

	// launch operands, captured at accept
	logic [KID_W-1:0] kid_q;
	logic [CNT_W-1:0] n_q;
	logic [TPB_W-1:0] t_q;
	logic [SHM_W-1:0] s_q;
	logic [RPT_W-1:0] rpt_q;
	logic [TPB_W-1:0] w_q;
	logic [RW-1:0]    r_q;
	logic [TPB_W:0]   in_tsum;
	logic [PW-1:0]    in_wprod;

	assign in_tsum  = (TPB_W+1)'(thread_count) + (TPB_W+1)'(WARP_SIZE - 1);
	assign in_wprod = PW'(in_tsum) * PW'(WM);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kid_q <= kernel_id;
			n_q   <= (block_count > MAX_LAUNCH) ? MAX_LAUNCH : block_count;
			t_q   <= thread_count;
			s_q   <= shared_per_block;
			rpt_q <= regs_per_thread;
			w_q   <= TPB_W'(in_wprod >> WK);
			r_q   <= RW'(thread_count) * RW'(regs_per_thread);
		end
	end

	// per-SM usage
	logic [BW-1:0]      blk_cnt_q [NUM_SMS];
	logic [WARPS_W-1:0] used_w_q  [NUM_SMS];
	logic [SHM_W-1:0]   used_s_q  [NUM_SMS];
	logic [REGS_W-1:0]  used_r_q  [NUM_SMS];

	// launch walk
	logic [IW-1:0]    i_q;
	logic             even_q;
	logic             retry_q;
	logic [CNT_W-1:0] count_q;

	logic          boundary, fail, fits, place, all_done;
	logic [IW-1:0] i_eff;
	logic [SW-1:0] wi;
	logic [AW-1:0] place_addr;

	always_comb begin
		boundary = (i_q >= eff_sms);
		i_eff    = boundary ? (even_q ? IW'(1) : IW'(0)) : i_q;
		fail     = boundary && retry_q;
		wi       = i_eff[SW-1:0];
		fits     = (i_eff < eff_sms)
			&& (blk_cnt_q[wi] < eff_blk)
			&& ((12'(used_w_q[wi]) + 12'(w_q)) <= 12'(warps_lim_q))
			&& ((22'(used_s_q[wi]) + 22'(s_q)) <= 22'(shared_lim_q))
			&& ((22'(used_r_q[wi]) + 22'(r_q)) <= 22'(regs_lim_q));
		place    = cmd.walk && !fail && fits;
		all_done = place && ((count_q + CNT_W'(1)) == n_q);
		place_addr = AW'(AW'(wi) * AW'(SLOTS_PER_SM) + AW'(blk_cnt_q[wi][JW-1:0]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q     <= '0;
			even_q  <= 1'b1;
			retry_q <= 1'b0;
			count_q <= '0;
		end else if (cmd.load) begin
			i_q     <= '0;
			even_q  <= 1'b1;
			retry_q <= 1'b0;
			count_q <= '0;
		end else if (cmd.walk && !fail) begin
			i_q <= i_eff + IW'(2);
			if (boundary) begin
				even_q  <= ~even_q;
				retry_q <= 1'b1;
			end
			if (place) begin
				retry_q <= 1'b0;
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	// release scan: issue side
	logic [IW-1:0] sm_r_q;
	logic [JW-1:0] j_r_q;
	logic [SW-1:0] si;
	logic          has, tok_last, scan_re;
	logic [AW-1:0] scan_raddr;

	always_comb begin
		si         = sm_r_q[SW-1:0];
		has        = (blk_cnt_q[si] != '0);
		tok_last   = !has || ((BW'(j_r_q) + BW'(1)) == blk_cnt_q[si]);
		scan_re    = cmd.scan && has;
		scan_raddr = AW'(AW'(si) * AW'(SLOTS_PER_SM) + AW'(j_r_q));
	end

	// release scan: retire side, one slot behind the issue
	logic          tok_v_s1, tok_rec_s1, tok_last_s1;
	logic [SW-1:0] tok_sm_s1;
	logic [BW-1:0]      wr_q;
	logic [WARPS_W-1:0] acc_w_q;
	logic [SHM_W-1:0]   acc_s_q;
	logic [REGS_W-1:0]  acc_r_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sm_r_q   <= '0;
			j_r_q    <= '0;
			tok_v_s1 <= 1'b0;
		end else if (cmd.load) begin
			sm_r_q   <= '0;
			j_r_q    <= '0;
			tok_v_s1 <= 1'b0;
		end else begin
			tok_v_s1 <= cmd.scan;
			if (cmd.scan) begin
				if (tok_last) begin
					sm_r_q <= sm_r_q + IW'(1);
					j_r_q  <= '0;
				end else begin
					j_r_q <= j_r_q + JW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan) begin
			tok_rec_s1  <= has;
			tok_last_s1 <= tok_last;
			tok_sm_s1   <= si;
		end
	end

	logic [REC_W-1:0]   rd;
	logic [TPB_W-1:0]   rd_t;
	logic [TPB_W:0]     rd_tsum;
	logic [PW-1:0]      rd_wprod;
	logic [TPB_W-1:0]   rd_w;
	logic [RW-1:0]      rd_r;
	logic               keep, fin;
	logic [WARPS_W-1:0] nacc_w;
	logic [SHM_W-1:0]   nacc_s;
	logic [REGS_W-1:0]  nacc_r;
	logic [BW-1:0]      nwr;
	logic [AW-1:0]      scan_waddr;

	always_comb begin
		rd_t     = rd[REC_T_LO +: TPB_W];
		rd_tsum  = (TPB_W+1)'(rd_t) + (TPB_W+1)'(WARP_SIZE - 1);
		rd_wprod = PW'(rd_tsum) * PW'(WM);
		rd_w     = TPB_W'(rd_wprod >> WK);
		rd_r     = RW'(rd_t) * RW'(rd[REC_R_LO +: RPT_W]);
		keep     = tok_v_s1 && tok_rec_s1 && (rd[KID_W-1:0] != kid_q);
		fin      = tok_v_s1 && tok_last_s1;
		nacc_w   = acc_w_q + (keep ? WARPS_W'(rd_w) : '0);
		nacc_s   = acc_s_q + (keep ? rd[REC_S_LO +: SHM_W] : '0);
		nacc_r   = acc_r_q + (keep ? REGS_W'(rd_r) : '0);
		nwr      = wr_q + (keep ? BW'(1) : '0);
		scan_waddr = AW'(AW'(tok_sm_s1) * AW'(SLOTS_PER_SM) + AW'(wr_q[JW-1:0]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			acc_w_q <= '0;
			acc_s_q <= '0;
			acc_r_q <= '0;
		end else if (cmd.load || fin) begin
			wr_q    <= '0;
			acc_w_q <= '0;
			acc_s_q <= '0;
			acc_r_q <= '0;
		end else if (tok_v_s1) begin
			wr_q    <= nwr;
			acc_w_q <= nacc_w;
			acc_s_q <= nacc_s;
			acc_r_q <= nacc_r;
		end
	end

	// usage update: placement adds, end of a scanned SM rewrites
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_SMS; k++) begin
				blk_cnt_q[k] <= '0;
				used_w_q[k]  <= '0;
				used_s_q[k]  <= '0;
				used_r_q[k]  <= '0;
			end
		end else if (place) begin
			blk_cnt_q[wi] <= blk_cnt_q[wi] + BW'(1);
			used_w_q[wi]  <= used_w_q[wi] + WARPS_W'(w_q);
			used_s_q[wi]  <= used_s_q[wi] + s_q;
			used_r_q[wi]  <= used_r_q[wi] + REGS_W'(r_q);
		end else if (fin) begin
			blk_cnt_q[tok_sm_s1] <= nwr;
			used_w_q[tok_sm_s1]  <= nacc_w;
			used_s_q[tok_sm_s1]  <= nacc_s;
			used_r_q[tok_sm_s1]  <= nacc_r;
		end
	end

	// slot records
	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [REC_W-1:0] ram_wdata;

	assign ram_we    = place || keep;
	assign ram_waddr = place ? place_addr : scan_waddr;
	assign ram_wdata = place ? {rpt_q, s_q, t_q, kid_q} : rd;

	sbd_ram #(
		.WIDTH (REC_W),
		.DEPTH (DEPTH)
	) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (scan_re),
		.raddr (scan_raddr),
		.rdata (rd)
	);

	// status to the sequencer
	always_comb begin
		stat.launch_empty = (block_count == '0);
		stat.no_sms       = (eff_sms == '0);
		stat.walk_end     = cmd.walk && (fail || all_done);
		stat.scan_end     = cmd.scan && tok_last && ((sm_r_q + IW'(1)) >= eff_sms);
	end

	// result register
	logic                result_valid_q;
	logic [SMIDX_W-1:0]  sm_index_q;
	logic                placed_q;
	logic [STAT_W-1:0]   status_q;
	logic [CNT_W-1:0]    unplaced_q;
	logic                last_q;
	logic                emit_fail;

	assign emit_fail = cmd.walk && fail;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= cmd.emit_empty || place || emit_fail || cmd.drain;
		end
	end

	always_ff @(posedge clk) begin
		sm_index_q <= place ? SMIDX_W'(i_eff) : '0;
		placed_q   <= place;
		unplaced_q <= emit_fail ? (n_q - count_q) : '0;
		last_q     <= cmd.emit_empty || all_done || emit_fail || cmd.drain;
		if (cmd.drain) begin
			status_q <= STAT_RELEASED;
		end else if (emit_fail) begin
			status_q <= STAT_NO_FIT;
		end else if (cmd.emit_empty || all_done) begin
			status_q <= STAT_ALL_PLACED;
		end else begin
			status_q <= STAT_PLACING;
		end
	end

	assign result_valid = result_valid_q;
	assign sm_index     = sm_index_q;
	assign placed       = placed_q;
	assign status       = status_q;
	assign unplaced     = unplaced_q;
	assign last         = last_q;
endmodule
`default_nettype wire

@@ test/sm_block_dispatcher_tb.sv @@
// Self-checking testbench for the thread-block dispatcher: random and directed launches/releases.
`default_nettype none
module sm_block_dispatcher_tb;
	import sbd_pkg::*;

	localparam int NSM     = 8;
	localparam int NSLOT   = 8;
	localparam int WSIZE   = 32;
	localparam int LIMIT   = 600000;
	localparam int N_RAND  = 160;

	typedef struct packed {
		logic [SMIDX_W-1:0] sm;
		logic               placed;
		logic [STAT_W-1:0]  status;
		logic [CNT_W-1:0]   unplaced;
		logic               last;
	} placement_t;

	// Occupancy model: per-SM usage and resident block records, plus the
	// five limit registers. note_item() expands one command into the
	// placements it should produce, check_result() pops the oldest.
	class occupancy_board;
		int unsigned warps_lim, shared_lim, regs_lim, blocks_lim, sms_lim;
		int unsigned blk_cnt [NSM];
		longint unsigned used_w [NSM], used_s [NSM], used_r [NSM];
		logic [KID_W-1:0] rec_kid [NSM][NSLOT];
		logic [TPB_W-1:0] rec_t   [NSM][NSLOT];
		logic [SHM_W-1:0] rec_s   [NSM][NSLOT];
		logic [RPT_W-1:0] rec_rpt [NSM][NSLOT];
		placement_t due [$];
		int errors;

		function new();
			warps_lim = WARPS_LIMIT_RST; shared_lim = SHARED_LIMIT_RST;
			regs_lim = REGS_LIMIT_RST; blocks_lim = BLOCKS_LIMIT_RST;
			sms_lim = SMS_IN_USE_RST;
			foreach (blk_cnt[i]) begin
				blk_cnt[i] = 0; used_w[i] = 0; used_s[i] = 0; used_r[i] = 0;
			end
			errors = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
			case (idx)
				CFG_WARPS_LIMIT:  warps_lim  = d[WARPS_W-1:0];
				CFG_SHARED_LIMIT: shared_lim = d[SHM_W-1:0];
				CFG_REGS_LIMIT:   regs_lim   = d[REGS_W-1:0];
				CFG_BLOCKS_LIMIT: blocks_lim = d[BLK_W-1:0];
				CFG_SMS_IN_USE:   sms_lim    = d[SMS_W-1:0];
				default: ;
			endcase
		endfunction

		function int unsigned n_sms();
			return sms_lim > NSM ? NSM : sms_lim;
		endfunction

		function void push(int unsigned sm, bit pl, logic [STAT_W-1:0] st,
				int unsigned un, bit lst);
			placement_t p;
			p.sm = SMIDX_W'(sm); p.placed = pl; p.status = st;
			p.unplaced = CNT_W'(un); p.last = lst;
			due.push_back(p);
		endfunction

		function bit fits(int unsigned sm, longint unsigned w, longint unsigned s,
				longint unsigned r);
			int unsigned bl;
			bl = blocks_lim > NSLOT ? NSLOT : blocks_lim;
			if (sm >= n_sms()) return 0;
			if (blk_cnt[sm] >= bl) return 0;
			if (used_w[sm] + w > warps_lim) return 0;
			if (used_s[sm] + s > shared_lim) return 0;
			if (used_r[sm] + r > regs_lim) return 0;
			return 1;
		endfunction

		function void release_kernel(logic [KID_W-1:0] kid);
			int unsigned wr;
			longint unsigned w, s, r;
			for (int sm = 0; sm < n_sms(); sm++) begin
				wr = 0; w = 0; s = 0; r = 0;
				for (int j = 0; j < blk_cnt[sm] && j < NSLOT; j++) begin
					if (rec_kid[sm][j] != kid) begin
						rec_kid[sm][wr] = rec_kid[sm][j];
						rec_t[sm][wr]   = rec_t[sm][j];
						rec_s[sm][wr]   = rec_s[sm][j];
						rec_rpt[sm][wr] = rec_rpt[sm][j];
						w += (longint'(rec_t[sm][j]) + WSIZE - 1) / WSIZE;
						s += rec_s[sm][j];
						r += longint'(rec_t[sm][j]) * rec_rpt[sm][j];
						wr++;
					end
				end
				blk_cnt[sm] = wr; used_w[sm] = w; used_s[sm] = s; used_r[sm] = r;
			end
			push(0, 0, STAT_RELEASED, 0, 1);
		endfunction

		function void note_item(logic o, logic [KID_W-1:0] kid, logic [CNT_W-1:0] cnt,
				logic [TPB_W-1:0] t, logic [SHM_W-1:0] s, logic [RPT_W-1:0] rpt);
			int unsigned n, done, i, slot;
			longint unsigned w, r;
			bit even, retry;
			if (o == OP_RELEASE) begin
				release_kernel(kid);
				return;
			end
			n = cnt > MAX_LAUNCH ? MAX_LAUNCH : cnt;
			if (n == 0) begin
				push(0, 0, STAT_ALL_PLACED, 0, 1);
				return;
			end
			w = (longint'(t) + WSIZE - 1) / WSIZE;
			r = longint'(t) * rpt;
			done = 0; i = 0; even = 1; retry = 0;
			// even SMs, then odd, alternating; a whole empty pass ends the walk
			while (done < n) begin
				if (i >= n_sms()) begin
					i = even ? 1 : 0;
					even = !even;
					if (retry) begin
						push(0, 0, STAT_NO_FIT, n - done, 1);
						return;
					end
					retry = 1;
				end
				if (fits(i, w, s, r)) begin
					slot = blk_cnt[i];
					retry = 0;
					rec_kid[i][slot] = kid; rec_t[i][slot] = t;
					rec_s[i][slot] = s; rec_rpt[i][slot] = rpt;
					blk_cnt[i] = slot + 1;
					used_w[i] += w; used_s[i] += s; used_r[i] += r;
					done++;
					if (done == n) push(i, 1, STAT_ALL_PLACED, 0, 1);
					else push(i, 1, STAT_PLACING, 0, 0);
				end
				i += 2;
			end
		endfunction

		function void check_result(placement_t got);
			placement_t exp_p;
			if (due.size() == 0) begin
				errors++;
				$display("%0t: unexpected result sm=%0d placed=%0d status=%0d unplaced=%0d last=%0d",
					$time, got.sm, got.placed, got.status, got.unplaced, got.last);
				return;
			end
			exp_p = due.pop_front();
			if (exp_p != got) begin
				errors++;
				$display("%0t: mismatch exp sm=%0d placed=%0d status=%0d unplaced=%0d last=%0d",
					$time, exp_p.sm, exp_p.placed, exp_p.status, exp_p.unplaced, exp_p.last);
				$display("%0t:          got sm=%0d placed=%0d status=%0d unplaced=%0d last=%0d",
					$time, got.sm, got.placed, got.status, got.unplaced, got.last);
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic                  op;
	logic [KID_W-1:0]      kernel_id;
	logic [CNT_W-1:0]      block_count;
	logic [TPB_W-1:0]      thread_count;
	logic [SHM_W-1:0]      shared_per_block;
	logic [RPT_W-1:0]      regs_per_thread;
	logic                  result_valid;
	logic [SMIDX_W-1:0]    sm_index;
	logic                  placed;
	logic [STAT_W-1:0]     status;
	logic [CNT_W-1:0]      unplaced;
	logic                  last;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	occupancy_board board;
	int cycles;
	int idle_pct;	// chance in a hundred that the sender idles before an item

	sm_block_dispatcher u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.op(op), .kernel_id(kernel_id), .block_count(block_count),
		.thread_count(thread_count), .shared_per_block(shared_per_block),
		.regs_per_thread(regs_per_thread),
		.result_valid(result_valid), .sm_index(sm_index), .placed(placed),
		.status(status), .unplaced(unplaced), .last(last),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Monitor: results are taken on the edge that closes their strobe cycle;
	// commands and register writes are noted on their handshake edge. Inputs
	// change only by NBA, so the values seen here are the ones the DUT sees.
	always @(posedge clk) begin
		placement_t got;
		if (arst_n) begin
			if (result_valid) begin
				got.sm = sm_index; got.placed = placed; got.status = status;
				got.unplaced = unplaced; got.last = last;
				board.check_result(got);
			end
			if (start && !busy)
				board.note_item(op, kernel_id, block_count, thread_count,
					shared_per_block, regs_per_thread);
			if (cfg_valid && cfg_ready)
				board.write_reg(cfg_index, cfg_data);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Issue one command. Called on a clock edge; returns on the edge that
	// accepted it with start still high, so back-to-back items need no
	// start toggle within a step.
	task automatic issue(logic o, logic [KID_W-1:0] kid, logic [CNT_W-1:0] cnt,
			logic [TPB_W-1:0] t, logic [SHM_W-1:0] s, logic [RPT_W-1:0] rpt);
		int gap;
		gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 8) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		op <= o; kernel_id <= kid; block_count <= cnt;
		thread_count <= t; shared_per_block <= s; regs_per_thread <= rpt;
		do @(posedge clk); while (busy);
	endtask

	// Hold off until every expected result is in and the block is idle.
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (board.due.size() != 0 || busy);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_limits(int unsigned w, int unsigned s, int unsigned r,
			int unsigned b, int unsigned n);
		write_reg(CFG_WARPS_LIMIT, CFG_DATA_W'(w));
		write_reg(CFG_SHARED_LIMIT, CFG_DATA_W'(s));
		write_reg(CFG_REGS_LIMIT, CFG_DATA_W'(r));
		write_reg(CFG_BLOCKS_LIMIT, CFG_DATA_W'(b));
		write_reg(CFG_SMS_IN_USE, CFG_DATA_W'(n));
	endtask

	// Random command. Mostly modest launches over a small pool of kernel
	// ids so releases find blocks; now and then full-range fields.
	task automatic random_item();
		logic o;
		logic [KID_W-1:0] kid;
		logic [CNT_W-1:0] cnt;
		logic [TPB_W-1:0] t;
		logic [SHM_W-1:0] s;
		logic [RPT_W-1:0] rpt;
		o   = ($urandom_range(99) < 25) ? OP_RELEASE : OP_LAUNCH;
		kid = KID_W'(($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(5));
		cnt = CNT_W'(($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(12));
		t   = TPB_W'(($urandom_range(7) == 0) ? $urandom_range(2047) : $urandom_range(1024));
		s   = SHM_W'(($urandom_range(7) == 0) ? $urandom_range(2097151)
			: $urandom_range(16384));
		rpt = RPT_W'(($urandom_range(7) == 0) ? $urandom_range(255) : $urandom_range(64));
		issue(o, kid, cnt, t, s, rpt);
	endtask

	initial begin
		board = new();
		cycles = 0;
		idle_pct = 0;
		arst_n = 1'b0;
		start = 1'b0; op = OP_LAUNCH; kernel_id = '0; block_count = '0;
		thread_count = '0; shared_per_block = '0; regs_per_thread = '0;
		cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, reset limits
		issue(OP_LAUNCH, 8'd1, 7'd0, 11'd64, 21'd0, 8'd0);            // empty launch
		issue(OP_LAUNCH, 8'd1, 7'd3, 11'd33, 21'd1024, 8'd32);        // warp rounding
		issue(OP_LAUNCH, 8'd2, 7'd127, 11'd0, 21'd0, 8'd255);         // saturated to 64
		issue(OP_LAUNCH, 8'd3, 7'd5, 11'd2047, 21'd2097151, 8'd255);  // no fit at all
		issue(OP_RELEASE, 8'd2, 7'd0, 11'd0, 21'd0, 8'd0);
		issue(OP_LAUNCH, 8'd255, 7'd64, 11'd1024, 21'd6144, 8'd64);
		issue(OP_RELEASE, 8'd9, 7'd127, 11'd2047, 21'd2097151, 8'd255); // no such kernel
		issue(OP_RELEASE, 8'd255, 7'd0, 11'd0, 21'd0, 8'd0);
		issue(OP_LAUNCH, 8'd4, 7'd10, 11'd256, 21'd8192, 8'd128);
		drain();
		// Lowered limits: SMs already over them must take nothing
		set_limits(1, 0, 0, 1, 15);                                   // too many SMs
		issue(OP_LAUNCH, 8'd5, 7'd2, 11'd0, 21'd0, 8'd0);
		issue(OP_RELEASE, 8'd4, 7'd0, 11'd0, 21'd0, 8'd0);
		issue(OP_LAUNCH, 8'd5, 7'd20, 11'd0, 21'd0, 8'd0);
		issue(OP_RELEASE, 8'd1, 7'd0, 11'd0, 21'd0, 8'd0);
		issue(OP_RELEASE, 8'd5, 7'd0, 11'd0, 21'd0, 8'd0);
		drain();
		set_limits(127, 2097151, 2097151, 15, 1);                     // single SM, too many slots
		issue(OP_LAUNCH, 8'd6, 7'd12, 11'd32, 21'd100, 8'd1);
		issue(OP_RELEASE, 8'd6, 7'd0, 11'd0, 21'd0, 8'd0);
		drain();
		write_reg(CFG_SMS_IN_USE, CFG_DATA_W'(0));                    // no SMs
		issue(OP_LAUNCH, 8'd7, 7'd4, 11'd32, 21'd0, 8'd1);
		issue(OP_RELEASE, 8'd7, 7'd0, 11'd0, 21'd0, 8'd0);
		drain();

		// Random phases: varied limits and sender idling
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin set_limits(64, 49152, 65536, 8, 8);        idle_pct = 0;  end
				1: begin set_limits(16, 32768, 32768, 4, 5);        idle_pct = 87; end
				2: begin set_limits(127, 1048576, 1048576, 8, 3);   idle_pct = 9;  end
				3: begin set_limits(0, 0, 0, 0, 8);                 idle_pct = 0;  end
				4: begin set_limits(48, 65536, 131072, 6, 15);      idle_pct = 87; end
				default: begin set_limits(8, 16384, 16384, 2, 2);   idle_pct = 9;  end
			endcase
			for (int k = 0; k < N_RAND / 6; k++)
				random_item();
			drain();
		end
		for (int k = 0; k < 8; k++)
			random_item();

		drain();
		repeat (20) @(posedge clk);
		if (board.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
`default_nettype wire

@@ sim.f @@
+incdir+hdl
hdl/sbd_pkg.sv
hdl/sbd_ram.sv
hdl/sbd_ctrl.sv
hdl/sbd_datapath.sv
hdl/sm_block_dispatcher.sv
test/sm_block_dispatcher_tb.sv
